FILE: design/mrua_pkg.sv
// shared types and constants of the multi-resource unit allocator
package mrua_pkg;

  localparam int unsigned AmtW     = 8;
  localparam int unsigned TypW     = 3;
  localparam int unsigned CntW     = 3;
  localparam int unsigned TiuW     = 3;
  // wide enough for a pair count or type count of up to eight
  localparam int unsigned SmallW   = 4;
  localparam int unsigned CfgDataW = 8;

  localparam logic [TiuW-1:0] TiuReset = 3'd4;
  localparam int unsigned     CfgTiu   = 0;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DENIED,
    ST_UNKNOWN,
    ST_UNDERFLOW
  } status_e;

  typedef enum logic {
    OP_ACQUIRE,
    OP_RELEASE
  } op_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_CHECK,
    S_COMMIT,
    S_FILL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic out_free;
  } seq_in_t;

  typedef struct packed {
    logic ready;
    logic accum;
    logic check;
    logic commit;
    logic fill;
    logic load_out;
  } seq_out_t;

endpackage

FILE: design/mrua_if.sv
// request and response channel interfaces of the allocator
interface mrua_req_if #(
  parameter int unsigned PAIRS_PER_REQUEST = 4
);
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [2:0]                          pair_count;
  logic [PAIRS_PER_REQUEST-1:0][2:0]   pair_type;
  logic [PAIRS_PER_REQUEST-1:0][7:0]   amount;

  modport source (
    output valid, operation, pair_count, pair_type, amount,
    input  ready
  );
  modport sink (
    input  valid, operation, pair_count, pair_type, amount,
    output ready
  );
endinterface

interface mrua_rsp_if #(
  parameter int unsigned PAIRS_PER_REQUEST = 4
);
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [PAIRS_PER_REQUEST-1:0][7:0]   free;

  modport source (
    output valid, status, free,
    input  ready
  );
  modport sink (
    input  valid, status, free,
    output ready
  );
endinterface

FILE: design/mrua_alu.sv
// shared add and subtract unit with borrow
module mrua_alu #(
  parameter int unsigned WIDTH = 10
) (
  input  mrua_pkg::alu_op_e  op_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic [WIDTH-1:0]   res_o,
  output logic               borrow_o
);
  import mrua_pkg::*;

  logic [WIDTH:0] full;

  always_comb begin
    unique case (op_i)
      ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default: full = '0;
    endcase
  end

  assign res_o    = full[WIDTH-1:0];
  assign borrow_o = full[WIDTH];

endmodule

FILE: design/mrua_seq.sv
// sequencer stepping pairs and types through the shared unit
module mrua_seq #(
  parameter int unsigned PAIRS_PER_REQUEST = 4,
  parameter int unsigned NUM_TYPES         = 4,
  parameter int unsigned IDX_W             = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrua_pkg::seq_in_t   ctl_i,
  output mrua_pkg::seq_out_t  ctl_o,
  output mrua_pkg::state_e    state_o,
  output logic [IDX_W-1:0]    idx_o
);
  import mrua_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_pair, last_type;

  assign last_pair = (idx_q == IDX_W'(PAIRS_PER_REQUEST - 1));
  assign last_type = (idx_q == IDX_W'(NUM_TYPES - 1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          state_d = S_ACCUM;
          idx_d   = '0;
        end
      end
      S_ACCUM: begin
        if (last_pair) begin
          state_d = S_CHECK;
          idx_d   = '0;
        end else begin
          idx_d = IDX_W'(idx_q + 1'b1);
        end
      end
      S_CHECK: begin
        if (last_type) begin
          state_d = S_COMMIT;
          idx_d   = '0;
        end else begin
          idx_d = IDX_W'(idx_q + 1'b1);
        end
      end
      S_COMMIT: begin
        if (last_type) begin
          state_d = S_FILL;
          idx_d   = '0;
        end else begin
          idx_d = IDX_W'(idx_q + 1'b1);
        end
      end
      S_FILL: begin
        if (last_pair) begin
          state_d = S_DONE;
          idx_d   = '0;
        end else begin
          idx_d = IDX_W'(idx_q + 1'b1);
        end
      end
      S_DONE: begin
        if (ctl_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_comb begin
    ctl_o          = '0;
    ctl_o.ready    = (state_q == S_IDLE);
    ctl_o.accum    = (state_q == S_ACCUM);
    ctl_o.check    = (state_q == S_CHECK);
    ctl_o.commit   = (state_q == S_COMMIT);
    ctl_o.fill     = (state_q == S_FILL);
    ctl_o.load_out = (state_q == S_DONE) && ctl_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign state_o = state_q;
  assign idx_o   = idx_q;

endmodule

FILE: design/multi_resource_unit_allocator_unit.sv
// multi-resource unit allocator: all-or-nothing acquire and release of unit counts
// requests are taken one at a time, only while idle, in steps set by the single shared
// adder walking pairs, then types twice, then pairs again
// a waiting response holds the next request in its last step until it is taken
// reset: held counts and capacities cleared, types_in_use 4, no clearing pass
module multi_resource_unit_allocator_unit #(
  parameter int unsigned NUM_TYPES         = 4,
  parameter int unsigned PAIRS_PER_REQUEST = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [$clog2(NUM_TYPES + 1)-1:0]       cfg_idx_i,
  input  logic [mrua_pkg::CfgDataW-1:0]          cfg_data_i,
  mrua_req_if.sink                               req_i,
  mrua_rsp_if.source                             rsp_o
);
  import mrua_pkg::*;

  localparam int unsigned CfgIW = $clog2(NUM_TYPES + 1);
  localparam int unsigned SumW  = AmtW + $clog2(PAIRS_PER_REQUEST);
  localparam int unsigned MaxPT = (PAIRS_PER_REQUEST > NUM_TYPES) ? PAIRS_PER_REQUEST
                                                                  : NUM_TYPES;
  localparam int unsigned IdxW  = (MaxPT > 1) ? $clog2(MaxPT) : 1;
  localparam int unsigned PIW   = (PAIRS_PER_REQUEST > 1) ? $clog2(PAIRS_PER_REQUEST) : 1;
  localparam int unsigned TIW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  seq_in_t   seq_i;
  seq_out_t  seq_o;
  state_e    state;
  logic [IdxW-1:0] idx;

  op_e                                      op_q;
  logic [SmallW-1:0]                        cnt_q;
  logic [PAIRS_PER_REQUEST-1:0][TypW-1:0]   typ_q;
  logic [PAIRS_PER_REQUEST-1:0][AmtW-1:0]   amt_q;
  logic [NUM_TYPES-1:0][SumW-1:0]           sum_q;
  status_e                                  stw_q;
  logic [PAIRS_PER_REQUEST-1:0][AmtW-1:0]   frs_q;

  logic [NUM_TYPES-1:0][AmtW-1:0]           held_q;
  logic [NUM_TYPES-1:0][AmtW-1:0]           cap_q;
  logic [TiuW-1:0]                          tiu_q;

  status_e                                  status_q;
  logic [PAIRS_PER_REQUEST-1:0][AmtW-1:0]   free_q;
  logic                                     out_valid_q;

  logic [SmallW-1:0] ntypes, cnt_in;
  logic [PIW-1:0]    pix;
  logic [TIW-1:0]    tix;
  logic [TypW-1:0]   cur_typ;
  logic              pair_on, pair_known, accept;
  logic [AmtW-1:0]   held_r, cap_r, free_r;
  logic [SumW-1:0]   sum_r;
  alu_op_e           alu_op;
  logic [SumW-1:0]   alu_a, alu_b, alu_res;
  logic              alu_borrow;

  // sequencer
  assign accept         = req_i.valid && seq_o.ready;
  assign seq_i.start    = accept;
  assign seq_i.out_free = !out_valid_q || rsp_o.ready;

  mrua_seq #(
    .PAIRS_PER_REQUEST (PAIRS_PER_REQUEST),
    .NUM_TYPES         (NUM_TYPES),
    .IDX_W             (IdxW)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (seq_i),
    .ctl_o   (seq_o),
    .state_o (state),
    .idx_o   (idx)
  );

  // operand selection
  assign ntypes = ({1'b0, tiu_q} > SmallW'(NUM_TYPES)) ? SmallW'(NUM_TYPES)
                                                       : {1'b0, tiu_q};
  assign cnt_in = ({1'b0, req_i.pair_count} > SmallW'(PAIRS_PER_REQUEST))
                  ? SmallW'(PAIRS_PER_REQUEST) : {1'b0, req_i.pair_count};

  assign pix        = PIW'(idx);
  assign cur_typ    = typ_q[pix];
  assign pair_on    = (SmallW'(idx) < cnt_q);
  assign pair_known = ({1'b0, cur_typ} < ntypes);
  assign tix        = (seq_o.accum || seq_o.fill) ? TIW'(cur_typ) : TIW'(idx);

  assign held_r = held_q[tix];
  assign cap_r  = cap_q[tix];
  assign sum_r  = sum_q[tix];
  assign free_r = (cap_r > held_r) ? AmtW'(cap_r - held_r) : '0;

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = sum_r;
    alu_b  = SumW'(amt_q[pix]);
    if (seq_o.check) begin
      alu_op = ALU_SUB;
      alu_a  = (op_q == OP_RELEASE) ? SumW'(held_r) : SumW'(free_r);
      alu_b  = sum_r;
    end else if (seq_o.commit) begin
      alu_op = (op_q == OP_RELEASE) ? ALU_SUB : ALU_ADD;
      alu_a  = SumW'(held_r);
      alu_b  = sum_r;
    end
  end

  mrua_alu #(
    .WIDTH (SumW)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiu_q <= TiuReset;
      cap_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIW'(CfgTiu)) begin
        tiu_q <= cfg_data_i[TiuW-1:0];
      end
      for (int i = 0; i < NUM_TYPES; i++) begin
        if (cfg_idx_i == CfgIW'(i + 1)) begin
          cap_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // held counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (seq_o.commit && stw_q == ST_OK) begin
      held_q[tix] <= alu_res[AmtW-1:0];
    end
  end

  // request working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(req_i.operation);
      cnt_q <= cnt_in;
      typ_q <= req_i.pair_type;
      amt_q <= req_i.amount;
      sum_q <= '0;
      stw_q <= ST_OK;
    end
    if (seq_o.accum && pair_on) begin
      if (pair_known) begin
        sum_q[tix] <= alu_res;
      end else begin
        stw_q <= ST_UNKNOWN;
      end
    end
    if (seq_o.check && stw_q == ST_OK && alu_borrow) begin
      stw_q <= (op_q == OP_RELEASE) ? ST_UNDERFLOW : ST_DENIED;
    end
    if (seq_o.fill) begin
      frs_q[pix] <= (pair_on && pair_known) ? free_r : '0;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_o.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_o.load_out) begin
      status_q <= stw_q;
      free_q   <= frs_q;
    end
  end

  assign req_i.ready  = seq_o.ready;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = status_q;
  assign rsp_o.free   = free_q;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while a request is in progress");

  a_held_only_in_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state != S_COMMIT |=> $stable(held_q))
    else $error("held counts changed outside commit");

  a_no_commit_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == S_COMMIT && stw_q != ST_OK |=> $stable(held_q))
    else $error("held counts changed on a failed request");

endmodule

FILE: verif/tb_multi_resource_unit_allocator_unit.sv
// testbench of the multi-resource unit allocator: table and random requests against a predictor
module tb_multi_resource_unit_allocator_unit;
  import mrua_pkg::*;

  localparam int unsigned NumTypes      = 4;
  localparam int unsigned Pairs         = 4;
  localparam int unsigned IdxW          = $clog2(NumTypes + 1);
  localparam int unsigned CfgCap0       = CfgTiu + 1;
  localparam int unsigned IdxSpare      = CfgCap0 + NumTypes;
  localparam int unsigned IdxTop        = 2 ** IdxW - 1;
  localparam int unsigned ItemsPerPhase = 215;
  localparam logic [5:0][TiuW-1:0] PhaseTiu = {3'd3, 3'd1, 3'd4, 3'd2, 3'd7, 3'd4};

  typedef struct packed {
    status_e                     status;
    logic [Pairs-1:0][AmtW-1:0]  free;
  } rsp_t;

  typedef struct packed {
    logic                        is_cfg;
    logic [IdxW-1:0]             idx;
    logic [CfgDataW-1:0]         data;
    op_e                         op;
    logic [CntW-1:0]             cnt;
    logic [Pairs-1:0][TypW-1:0]  typ;
    logic [Pairs-1:0][AmtW-1:0]  amt;
    logic                        chk;
    rsp_t                        exp;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [IdxW-1:0]       cfg_idx_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  mrua_req_if #(.PAIRS_PER_REQUEST(Pairs)) req_if ();
  mrua_rsp_if #(.PAIRS_PER_REQUEST(Pairs)) rsp_if ();

  multi_resource_unit_allocator_unit #(
    .NUM_TYPES        (NumTypes),
    .PAIRS_PER_REQUEST(Pairs)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  // allocator state as the predictor sees it
  logic [TiuW-1:0]  tiu_m;
  logic [AmtW-1:0]  cap_m  [NumTypes];
  logic [AmtW-1:0]  held_m [NumTypes];

  rsp_t  due_rsp [$];
  step_t dir_tab [$];
  int    n_sent;
  int    n_got;
  int    errs;
  int    burst_left;
  logic  exp_typed;
  rsp_t  exp_fixed;

  function automatic logic [AmtW-1:0] free_units(int t);
    return (cap_m[t] > held_m[t]) ? cap_m[t] - held_m[t] : '0;
  endfunction

  function automatic rsp_t settle_request(step_t s);
    rsp_t r;
    int   n;
    int   ntyp;
    bit   known [Pairs];
    int   need [NumTypes];
    r.status = ST_OK;
    r.free   = '0;
    ntyp = (tiu_m > NumTypes) ? NumTypes : tiu_m;
    n    = (s.cnt > Pairs) ? Pairs : s.cnt;
    foreach (need[t]) need[t] = 0;
    foreach (known[k]) known[k] = 1'b0;
    for (int k = 0; k < n; k++) begin
      known[k] = s.typ[k] < ntyp;
      if (known[k]) need[s.typ[k]] += s.amt[k];
      else r.status = ST_UNKNOWN;
    end
    if (r.status == ST_OK) begin
      for (int t = 0; t < ntyp; t++) begin
        if (s.op == OP_ACQUIRE && need[t] > free_units(t)) r.status = ST_DENIED;
        if (s.op == OP_RELEASE && need[t] > held_m[t]) r.status = ST_UNDERFLOW;
      end
    end
    if (r.status == ST_OK) begin
      for (int t = 0; t < ntyp; t++) begin
        if (s.op == OP_ACQUIRE) held_m[t] = AmtW'(held_m[t] + need[t]);
        else held_m[t] = AmtW'(held_m[t] - need[t]);
      end
    end
    for (int k = 0; k < n; k++)
      if (known[k]) r.free[k] = free_units(s.typ[k]);
    return r;
  endfunction

  function automatic step_t rq(op_e op, int cnt, int t0, int a0, int t1, int a1,
                               int t2, int a2, int t3, int a3);
    step_t s;
    s     = '0;
    s.op  = op;
    s.cnt = CntW'(cnt);
    s.typ = {TypW'(t3), TypW'(t2), TypW'(t1), TypW'(t0)};
    s.amt = {AmtW'(a3), AmtW'(a2), AmtW'(a1), AmtW'(a0)};
    return s;
  endfunction

  function automatic step_t known_as(step_t s, status_e st);
    s.chk        = 1'b1;
    s.exp.status = st;
    s.exp.free   = '0;
    return s;
  endfunction

  function automatic step_t reg_row(int idx, int data);
    step_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.idx    = IdxW'(idx);
    s.data   = CfgDataW'(data);
    return s;
  endfunction

  task automatic add_row(input step_t s);
    dir_tab.insert(dir_tab.size(), s);
  endtask

  task automatic issue(input step_t s);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= s.op;
    req_if.pair_count <= s.cnt;
    req_if.pair_type  <= s.typ;
    req_if.amount     <= s.amt;
    exp_typed         <= s.chk;
    exp_fixed         <= s.exp;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
    burst_left--;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (n_got != n_sent) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input int idx, input int data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= IdxW'(idx);
    cfg_data_i <= CfgDataW'(data);
    @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // predictor update and response check
  always @(posedge clk_i) begin : rsp_check
    rsp_t  want;
    step_t seen;
    if (!rst_ni) begin
      tiu_m = TiuReset;
      foreach (cap_m[t]) cap_m[t] = '0;
      foreach (held_m[t]) held_m[t] = '0;
      due_rsp.delete();
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_got++;
        if (due_rsp.size() == 0) begin
          errs++;
          $display("%0t: unexpected response, expected none, actual status %0d",
                   $time, rsp_if.status);
        end else begin
          want = due_rsp.pop_front();
          if (rsp_if.status !== want.status) begin
            errs++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp_if.status);
          end
          for (int k = 0; k < Pairs; k++) begin
            if (rsp_if.free[k] !== want.free[k]) begin
              errs++;
              $display("%0t: free_%0d mismatch, expected %0d, actual %0d",
                       $time, k, want.free[k], rsp_if.free[k]);
            end
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgTiu) tiu_m = cfg_data_i[TiuW-1:0];
        else if (cfg_idx_i < IdxSpare) cap_m[cfg_idx_i - CfgCap0] = cfg_data_i;
      end
      if (req_if.valid && req_if.ready) begin
        seen     = '0;
        seen.op  = op_e'(req_if.operation);
        seen.cnt = req_if.pair_count;
        seen.typ = req_if.pair_type;
        seen.amt = req_if.amount;
        want     = settle_request(seen);
        due_rsp.insert(due_rsp.size(), exp_typed ? exp_fixed : want);
      end
    end
  end

  // receiver stalls, with one long hold-off once the traffic is well under way
  initial begin : rsp_stall
    int  seg;
    int  mode;
    bit  held_off;
    held_off = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held_off && n_sent >= 500) begin
        held_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(8, 60);
        repeat (seg) begin
          case (mode)
            0: begin
              rsp_if.ready <= 1'b1;
            end
            1: begin
              rsp_if.ready <= ($urandom_range(0, 9) < 7);
            end
            2: begin
              rsp_if.ready <= ~rsp_if.ready;
            end
            default: begin
              rsp_if.ready <= ($urandom_range(0, 3) == 0);
            end
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stim
    step_t row;
    bit    cfg_open;
    int    eff;
    n_sent     = 0;
    n_got      = 0;
    errs       = 0;
    burst_left = 0;
    cfg_open   = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_data_i        <= '0;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_ACQUIRE;
    req_if.pair_count <= '0;
    req_if.pair_type  <= '0;
    req_if.amount     <= '0;
    exp_typed         <= 1'b0;
    exp_fixed         <= '0;

    // state straight after reset
    add_row(known_as(rq(OP_ACQUIRE, 0, 7, 255, 7, 255, 7, 255, 7, 255), ST_OK));
    add_row(known_as(rq(OP_ACQUIRE, 1, 0, 1, 7, 0, 7, 0, 7, 0), ST_DENIED));
    add_row(known_as(rq(OP_RELEASE, 1, 3, 1, 7, 0, 7, 0, 7, 0), ST_UNDERFLOW));
    add_row(known_as(rq(OP_ACQUIRE, 2, 0, 0, 4, 9, 7, 0, 7, 0), ST_UNKNOWN));
    add_row(known_as(rq(OP_RELEASE, 4, 0, 0, 1, 0, 2, 0, 3, 0), ST_OK));
    add_row(reg_row(CfgTiu, 8'hFC));
    add_row(reg_row(CfgCap0, 255));
    add_row(reg_row(CfgCap0 + 1, 200));
    add_row(reg_row(CfgCap0 + 2, 1));
    add_row(reg_row(CfgCap0 + 3, 0));
    add_row(reg_row(IdxSpare, 8'hA5));
    add_row(reg_row(IdxTop, 8'h5A));
    add_row(rq(OP_ACQUIRE, 4, 0, 255, 1, 200, 2, 1, 3, 0));
    add_row(rq(OP_ACQUIRE, 1, 0, 1, 7, 255, 7, 255, 7, 255));
    // same type twice in one request
    add_row(rq(OP_RELEASE, 2, 0, 128, 0, 127, 7, 255, 7, 255));
    add_row(rq(OP_RELEASE, 1, 0, 1, 7, 0, 7, 0, 7, 0));
    add_row(rq(OP_RELEASE, 1, 1, 200, 7, 0, 7, 0, 7, 0));
    add_row(rq(OP_ACQUIRE, 2, 1, 150, 1, 100, 7, 0, 7, 0));
    // pair count saturates
    add_row(rq(OP_ACQUIRE, 7, 1, 100, 1, 100, 2, 1, 3, 0));
    add_row(rq(OP_RELEASE, 5, 2, 1, 6, 0, 0, 0, 0, 0));
    // capacity of type 1 lowered while none of it is held
    add_row(reg_row(CfgCap0 + 1, 50));
    add_row(reg_row(CfgTiu, 7));
    add_row(rq(OP_ACQUIRE, 1, 1, 0, 7, 0, 7, 0, 7, 0));
    add_row(rq(OP_ACQUIRE, 1, 1, 1, 7, 0, 7, 0, 7, 0));
    add_row(rq(OP_RELEASE, 1, 1, 200, 7, 0, 7, 0, 7, 0));
    add_row(reg_row(CfgTiu, 0));
    add_row(rq(OP_RELEASE, 1, 0, 0, 7, 0, 7, 0, 7, 0));
    add_row(rq(OP_ACQUIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(reg_row(CfgTiu, 1));
    add_row(rq(OP_ACQUIRE, 2, 0, 5, 1, 5, 7, 0, 7, 0));
    add_row(rq(OP_ACQUIRE, 6, 0, 1, 0, 2, 0, 4, 0, 8));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!cfg_open) begin
          drain();
          cfg_open = 1'b1;
        end
        cfg_write(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        issue(dir_tab[i]);
      end
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      cfg_write(CfgTiu, {5'($urandom), PhaseTiu[p]});
      for (int t = 0; t < NumTypes; t++) begin
        case ($urandom_range(0, 9))
          0: cfg_write(CfgCap0 + t, 0);
          1: cfg_write(CfgCap0 + t, 255);
          default: cfg_write(CfgCap0 + t, $urandom_range(1, 254));
        endcase
      end
      if (p == 2) cfg_write(IdxSpare + 1, $urandom_range(0, 255));
      cfg_we_i <= 1'b0;
      eff = (PhaseTiu[p] > NumTypes) ? NumTypes : PhaseTiu[p];
      repeat (ItemsPerPhase) begin
        row     = '0;
        row.op  = op_e'($urandom_range(0, 1));
        row.cnt = CntW'($urandom);
        row.typ = (Pairs * TypW)'($urandom);
        row.amt = (Pairs * AmtW)'($urandom);
        // mostly well-formed requests with modest amounts, the rest noise
        if ($urandom_range(0, 9) < 8 && eff > 0) begin
          row.cnt = CntW'($urandom_range(1, Pairs));
          for (int k = 0; k < Pairs; k++) begin
            row.typ[k] = TypW'($urandom_range(0, eff - 1));
            row.amt[k] = ($urandom_range(0, 3) == 0) ? AmtW'($urandom)
                                                     : AmtW'($urandom_range(0, 24));
          end
        end
        issue(row);
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (errs == 0 && due_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
design/mrua_pkg.sv
design/mrua_if.sv
design/mrua_alu.sv
design/mrua_seq.sv
design/multi_resource_unit_allocator_unit.sv
verif/tb_multi_resource_unit_allocator_unit.sv
